### sv/spt_pkg.sv
// Subnet prefix table: shared types, codes and sizes.
// Used by every module of the block; depends on nothing.
package spt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_length;
    logic [7:0]  entry_index;
  } spt_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] match_index;
    logic [8:0] entry_count;
  } spt_rsp_t;

  typedef struct packed {
    logic        family;
    logic [7:0]  prefix;
    logic [63:0] high;
    logic [63:0] low;
  } spt_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    spt_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } spt_mem_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REM_RD,
    S_REM_WR,
    S_SCAN
  } spt_state_e;

endpackage

### sv/spt_table.sv
// Subnet table storage: one write port, one registered read port.
// Depends on spt_pkg.
module spt_table (
  input  logic                  clk_i,
  input  spt_pkg::spt_mem_ctl_t ctl_i,
  output spt_pkg::spt_entry_t   rdata_o
);
  import spt_pkg::*;

  spt_entry_t mem_q [TABLE_DEPTH];
  spt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[ctl_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spt_match.sv
// Prefix compare unit: one stored entry against the lookup address.
// Depends on spt_pkg.
module spt_match (
  input  logic                is_ipv6_i,
  input  logic [63:0]         address_high_i,
  input  logic [63:0]         address_low_i,
  input  spt_pkg::spt_entry_t entry_i,
  output logic                hit_o
);
  import spt_pkg::*;

  logic [127:0] diff;
  logic [127:0] mask6;
  logic [31:0]  mask4;
  logic         bits_eq;

  // Shifts of 32 or 128 and more give an all-ones mask: long prefixes saturate.
  assign diff    = {address_high_i, address_low_i} ^ {entry_i.high, entry_i.low};
  assign mask6   = ~({128{1'b1}} >> entry_i.prefix);
  assign mask4   = ~({32{1'b1}} >> entry_i.prefix);
  assign bits_eq = is_ipv6_i ? ~|(diff & mask6) : ~|(diff[31:0] & mask4);
  assign hit_o   = (entry_i.family == is_ipv6_i) && bits_eq;

endmodule

### sv/subnet_prefix_table_match.sv
// Subnet prefix table, top level: sequencer around the table and compare unit.
// done_o is registered. Full, bad index, empty lookup and unused kind answer
// from idle; insert and remove pass through their own states; lookup scans
// down from the last of N valid entries, one slot a cycle through the single
// read port. One request at a time; busy_o is low again in the done_o cycle.
// Reset clears the entry count and sequencer; table contents are not cleared.
module subnet_prefix_table_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  spt_pkg::spt_req_t req_i,
  output logic              done_o,
  output spt_pkg::spt_rsp_t rsp_o
);
  import spt_pkg::*;

  spt_state_e       state_q, state_d;
  spt_req_t         req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             done_q, done_d;
  spt_rsp_t         rsp_q, rsp_d;
  spt_mem_ctl_t     mem_ctl;
  spt_entry_t       rd_entry;
  logic             hit;
  logic             accept;

  assign accept = start_i && (state_q == S_IDLE);

  spt_table u_table (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .rdata_o (rd_entry)
  );

  spt_match u_match (
    .is_ipv6_i      (req_q.is_ipv6),
    .address_high_i (req_q.address_high),
    .address_low_i  (req_q.address_low),
    .entry_i        (rd_entry),
    .hit_o          (hit)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (req_i.kind)
            KIND_INSERT: if (count_q != CNT_W'(TABLE_DEPTH)) state_d = S_INSERT;
            KIND_REMOVE: if (CNT_W'(req_i.entry_index) < count_q) state_d = S_REM_RD;
            KIND_LOOKUP: if (count_q != '0) state_d = S_SCAN;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_INSERT: state_d = S_IDLE;
      S_REM_RD: state_d = S_REM_WR;
      S_REM_WR: state_d = S_IDLE;
      S_SCAN: begin
        if (pend_q && (hit || pend_idx_q == '0)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    count_d       = count_q;
    addr_d        = addr_q;
    issue_d       = issue_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    mem_ctl.we    = 1'b0;
    mem_ctl.waddr = count_q[IDX_W-1:0];
    mem_ctl.wdata = '{family: req_q.is_ipv6, prefix: req_q.prefix_length,
                      high: req_q.address_high, low: req_q.address_low};
    mem_ctl.re    = 1'b0;
    mem_ctl.raddr = addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d = '{status: ST_OK, found: 1'b0, match_index: '0,
                    entry_count: 9'(count_q)};
          priority case (req_i.kind)
            KIND_INSERT: begin
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FULL;
              end
            end
            KIND_REMOVE: begin
              if (CNT_W'(req_i.entry_index) >= count_q) begin
                done_d       = 1'b1;
                rsp_d.status = ST_BAD_INDEX;
              end
            end
            KIND_LOOKUP: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                addr_d  = IDX_W'(count_q - 1'b1);
                issue_d = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_INSERT: begin
        mem_ctl.we        = 1'b1;
        count_d           = count_q + 1'b1;
        done_d            = 1'b1;
        rsp_d.entry_count = 9'(count_q + 1'b1);
      end
      S_REM_RD: begin
        mem_ctl.re    = 1'b1;
        mem_ctl.raddr = IDX_W'(count_q - 1'b1);
      end
      S_REM_WR: begin
        mem_ctl.we        = 1'b1;
        mem_ctl.waddr     = IDX_W'(req_q.entry_index);
        mem_ctl.wdata     = rd_entry;
        count_d           = count_q - 1'b1;
        done_d            = 1'b1;
        rsp_d.entry_count = 9'(count_q - 1'b1);
      end
      S_SCAN: begin
        if (issue_q) begin
          mem_ctl.re = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = addr_q;
          if (addr_q == '0) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q - 1'b1;
          end
        end
        if (pend_q && hit) begin
          done_d            = 1'b1;
          rsp_d.found       = 1'b1;
          rsp_d.match_index = 8'(pend_idx_q);
          issue_d           = 1'b0;
          pend_d            = 1'b0;
        end else if (pend_q && pend_idx_q == '0) begin
          done_d  = 1'b1;
          issue_d = 1'b0;
          pend_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    addr_q     <= addr_d;
    pend_idx_q <= pend_idx_d;
    rsp_q      <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### sv/spt_check.sv
// Port-level checks for the subnet prefix table, bound to the top level.
// Depends on spt_pkg and subnet_prefix_table_match.
module spt_check (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input spt_pkg::spt_rsp_t rsp_o
);
  import spt_pkg::*;

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.found |-> rsp_o.status == ST_OK &&
                              {1'b0, rsp_o.match_index} < rsp_o.entry_count)
    else $error("match index outside valid entries");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_FULL |-> rsp_o.entry_count == 9'(TABLE_DEPTH))
    else $error("full status with free slots");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.entry_count <= 9'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.found |-> rsp_o.match_index == '0)
    else $error("match index set without a match");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a request");

endmodule

bind subnet_prefix_table_match spt_check u_check (.*);
